FILE: rtl/core/tsp_pkg.sv
// Shared constants and helpers for the trackball sphere projection block.
package tsp_pkg;

  localparam int unsigned FracBitsDef = 14;

  localparam int unsigned PosW     = 12;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned OutW     = 16;
  localparam int unsigned OutZW    = 15;
  localparam int unsigned OutFracW = 14;

  localparam logic [DimW-1:0] DimMax = 13'd4096;
  localparam logic [DimW-1:0] DimMin = 13'd1;

  localparam logic [DimW-1:0] WidthRst  = 13'd640;
  localparam logic [DimW-1:0] HeightRst = 13'd480;

  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;

  // Force a window dimension into its legal range.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimMin;
    end else if (v > DimMax) begin
      r = DimMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tsp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tsp_div #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 13,
  parameter int unsigned QW = 15,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_s  [QW+1];
  logic [DW-1:0] den_s  [QW+1];
  logic [QW-1:0] lo_s   [QW+1];
  logic [QW-1:0] quo_s  [QW+1];
  logic [SW-1:0] side_s [QW+1];
  logic          valid_s[QW+1];

  // Quotient is known to fit QW bits, so the top part is already below den.
  assign rem_s[0]   = DW'(num_i >> QW);
  assign den_s[0]   = den_i;
  assign lo_s[0]    = num_i[QW-1:0];
  assign quo_s[0]   = '0;
  assign side_s[0]  = side_i;
  assign valid_s[0] = valid_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_d;

    always_comb begin
      t     = {rem_s[k], lo_s[k][QW-1]};
      diff  = t - {1'b0, den_s[k]};
      ge    = t >= {1'b0, den_s[k]};
      rem_d = ge ? diff[DW-1:0] : t[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_s[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_s[k+1] <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= rem_d;
        den_s[k+1]  <= den_s[k];
        lo_s[k+1]   <= {lo_s[k][QW-2:0], 1'b0};
        quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = valid_s[QW];
  assign quo_o   = quo_s[QW];
  assign side_o  = side_s[QW];

endmodule

FILE: rtl/core/tsp_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module tsp_sqrt #(
  parameter int unsigned VW = 30,
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [VW-1:0]     val_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [VW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int unsigned RW = VW / 2;

  logic [RW+1:0] rem_s  [RW+1];
  logic [RW-1:0] root_s [RW+1];
  logic [VW-1:0] lo_s   [RW+1];
  logic [SW-1:0] side_s [RW+1];
  logic          valid_s[RW+1];

  assign rem_s[0]   = '0;
  assign root_s[0]  = '0;
  assign lo_s[0]    = val_i;
  assign side_s[0]  = side_i;
  assign valid_s[0] = valid_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    always_comb begin
      t     = {rem_s[k][RW:0], lo_s[k][VW-1:VW-2]};
      trial = {1'b0, root_s[k], 2'b01};
      diff  = t - trial;
      ge    = t >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_s[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_s[k+1] <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge ? diff[RW+1:0] : t[RW+1:0];
        root_s[k+1] <= {root_s[k][RW-2:0], ge};
        lo_s[k+1]   <= {lo_s[k][VW-3:0], 2'b00};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = valid_s[RW];
  assign root_o  = root_s[RW];
  assign side_o  = side_s[RW];

endmodule

FILE: rtl/core/tsp_fifo.sv
// Two-entry register queue between the front and back pipelines.
module tsp_fifo #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q[2];
  logic         wr_q, wr_d;
  logic         rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/tsp_front.sv
// Front pipeline: clamp the cursor and normalise both axes to signed fixed point.
module tsp_front #(
  parameter int unsigned FracBits = tsp_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tsp_pkg::PosW-1:0]    x_i,
  input  logic [tsp_pkg::PosW-1:0]    y_i,
  input  logic [tsp_pkg::DimW-1:0]    w_i,
  input  logic [tsp_pkg::DimW-1:0]    h_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FracBits+1:0]  nx_o,
  output logic signed [FracBits+1:0]  ny_o
);
  import tsp_pkg::*;

  localparam int unsigned NW = DimW + FracBits;
  localparam int unsigned QW = FracBits + 1;

  logic [DimW-1:0]        xc, yc, mx, my;
  logic signed [DimW+1:0] dx, dy, ndx, ndy;
  logic                   neg_x, neg_y, sx, sy, en;
  logic [NW-1:0]          num_x, num_y;
  logic [QW-1:0]          qx, qy;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    xc    = ({1'b0, x_i} > w_i) ? w_i : {1'b0, x_i};
    yc    = ({1'b0, y_i} > h_i) ? h_i : {1'b0, y_i};
    // x grows to the right, y is flipped so that up is positive
    dx    = $signed({1'b0, xc, 1'b0}) - $signed({2'b00, w_i});
    dy    = $signed({2'b00, h_i}) - $signed({1'b0, yc, 1'b0});
    ndx   = -dx;
    ndy   = -dy;
    neg_x = dx[DimW+1];
    neg_y = dy[DimW+1];
    mx    = neg_x ? ndx[DimW-1:0] : dx[DimW-1:0];
    my    = neg_y ? ndy[DimW-1:0] : dy[DimW-1:0];
    // add half the divisor for round half away from zero
    num_x = {mx, {FracBits{1'b0}}} + NW'(w_i >> 1);
    num_y = {my, {FracBits{1'b0}}} + NW'(h_i >> 1);
  end

  tsp_div #(.NW(NW), .DW(DimW), .QW(QW), .SW(1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .num_i(num_x), .den_i(w_i), .side_i(neg_x),
    .valid_o(out_valid_o), .quo_o(qx), .side_o(sx)
  );

  tsp_div #(.NW(NW), .DW(DimW), .QW(QW), .SW(1)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .num_i(num_y), .den_i(h_i), .side_i(neg_y),
    .valid_o(), .quo_o(qy), .side_o(sy)
  );

  assign nx_o = sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ny_o = sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

endmodule

FILE: rtl/core/tsp_back.sv
// Back pipeline: sphere height, vector length and unit-vector division.
module tsp_back #(
  parameter int unsigned FracBits = tsp_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [FracBits+1:0]        nx_i,
  input  logic signed [FracBits+1:0]        ny_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tsp_pkg::OutW-1:0]   dir_x_o,
  output logic signed [tsp_pkg::OutW-1:0]   dir_y_o,
  output logic [tsp_pkg::OutZW-1:0]         dir_z_o
);
  import tsp_pkg::*;

  localparam int unsigned CW  = FracBits + 2;
  localparam int unsigned MW  = FracBits + 1;
  localparam int unsigned SqW = 2 * FracBits + 2;
  localparam int unsigned ND  = MW + OutFracW + 1;
  localparam logic [SqW-1:0] One2 = SqW'(1) << (2 * FracBits);
  localparam logic [SqW-1:0] KSph = One2 + SqW'((One2 + 500) / 1000);

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // square both planar components
  logic signed [CW-1:0] nx1_q, ny1_q, nx2_q, ny2_q;
  logic [SqW-1:0]       sqx1_q, sqy1_q, sxy2_q, zarg2_q;
  logic                 v1_q, v2_q;
  logic [MW-1:0]        ax0, ay0;
  logic [CW-1:0]        nnx, nny;

  always_comb begin
    nnx = -nx_i;
    nny = -ny_i;
    ax0 = nx_i[CW-1] ? nnx[MW-1:0] : nx_i[MW-1:0];
    ay0 = ny_i[CW-1] ? nny[MW-1:0] : ny_i[MW-1:0];
  end

  // planar length clamped to one, then the height argument
  logic [SqW-1:0] sxy1, d2;
  assign sxy1 = sqx1_q + sqy1_q;
  assign d2   = (sxy1 > One2) ? One2 : sxy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx1_q   <= nx_i;
      ny1_q   <= ny_i;
      sqx1_q  <= ax0 * ax0;
      sqy1_q  <= ay0 * ay0;
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      sxy2_q  <= sxy1;
      zarg2_q <= KSph - d2;
    end
  end

  logic                 v3;
  logic [MW-1:0]        z3;
  logic signed [CW-1:0] nx3, ny3;
  logic [SqW-1:0]       sxy3;

  tsp_sqrt #(.VW(SqW), .SW(2 * CW + SqW)) u_sqrt_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .val_i(zarg2_q),
    .side_i({nx2_q, ny2_q, sxy2_q}),
    .valid_o(v3), .root_o(z3), .side_o({nx3, ny3, sxy3})
  );

  // sum of all three squares
  logic                 v4_q, v5_q;
  logic signed [CW-1:0] nx4_q, ny4_q, nx5_q, ny5_q;
  logic [MW-1:0]        z4_q, z5_q;
  logic [SqW-1:0]       sxy4_q, zsq4_q, tot5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx4_q  <= nx3;
      ny4_q  <= ny3;
      z4_q   <= z3;
      sxy4_q <= sxy3;
      zsq4_q <= z3 * z3;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      z5_q   <= z4_q;
      tot5_q <= sxy4_q + zsq4_q;
    end
  end

  logic                 v6;
  logic [MW-1:0]        len6, lenc;
  logic signed [CW-1:0] nx6, ny6;
  logic [MW-1:0]        z6;

  tsp_sqrt #(.VW(SqW), .SW(2 * CW + MW)) u_sqrt_len (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .val_i(tot5_q),
    .side_i({nx5_q, ny5_q, z5_q}),
    .valid_o(v6), .root_o(len6), .side_o({nx6, ny6, z6})
  );

  // scale each component to Q1.14 and divide by the length, rounded
  logic [MW-1:0] ax6, ay6;
  logic [CW-1:0] nnx6, nny6;
  logic [ND-1:0] num_x, num_y, num_z;

  always_comb begin
    lenc  = (len6 == '0) ? MW'(1) : len6;
    nnx6  = -nx6;
    nny6  = -ny6;
    ax6   = nx6[CW-1] ? nnx6[MW-1:0] : nx6[MW-1:0];
    ay6   = ny6[CW-1] ? nny6[MW-1:0] : ny6[MW-1:0];
    num_x = ND'({ax6, {OutFracW{1'b0}}}) + ND'(lenc >> 1);
    num_y = ND'({ay6, {OutFracW{1'b0}}}) + ND'(lenc >> 1);
    num_z = ND'({z6, {OutFracW{1'b0}}}) + ND'(lenc >> 1);
  end

  logic [OutZW-1:0] qx, qy;
  logic             sx, sy;

  tsp_div #(.NW(ND), .DW(MW), .QW(OutZW), .SW(1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6), .num_i(num_x), .den_i(lenc),
    .side_i(nx6[CW-1]), .valid_o(out_valid_o), .quo_o(qx), .side_o(sx)
  );

  tsp_div #(.NW(ND), .DW(MW), .QW(OutZW), .SW(1)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6), .num_i(num_y), .den_i(lenc),
    .side_i(ny6[CW-1]), .valid_o(), .quo_o(qy), .side_o(sy)
  );

  tsp_div #(.NW(ND), .DW(MW), .QW(OutZW), .SW(1)) u_div_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6), .num_i(num_z), .den_i(lenc),
    .side_i(1'b0), .valid_o(), .quo_o(dir_z_o), .side_o()
  );

  assign dir_x_o = sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign dir_y_o = sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

endmodule

FILE: rtl/core/trackball_sphere_projection.sv
// Path: push enters the front dividers, then the queue, then the back squares, two
// pipelined square roots and the output dividers; each unit has a stage per result bit.
// Throughput: one word per cycle, unless back-pressure from pop holds the pipelines.
// Reset: asynchronous, active low; empties every pipeline and the queue, and loads
// window width 640 and height 480.
// Top level: trackball sphere projection, front and back pipelines with a queue between.
module trackball_sphere_projection #(
  parameter int unsigned FRAC_BITS = tsp_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input word
  input  logic                             push,
  output logic                             full,
  input  logic [tsp_pkg::PosW-1:0]         cursor_x_i,
  input  logic [tsp_pkg::PosW-1:0]         cursor_y_i,
  // result word
  output logic                             empty,
  input  logic                             pop,
  output logic signed [tsp_pkg::OutW-1:0]  dir_x_o,
  output logic signed [tsp_pkg::OutW-1:0]  dir_y_o,
  output logic [tsp_pkg::OutZW-1:0]        dir_z_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [tsp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsp_pkg::DimW-1:0]         cfg_data_i
);
  import tsp_pkg::*;

  localparam int unsigned CW = FRAC_BITS + 2;

  // Window dimensions are held already clamped to 1..4096, so the
  // datapath never sees a zero or oversized divisor.
  logic [DimW-1:0] width_q, width_d, height_q, height_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWidth:  width_d  = clamp_dim(cfg_data_i);
        RegHeight: height_d = clamp_dim(cfg_data_i);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Front: clamp the cursor and normalise each axis to [-1, 1].
  logic                 f_ready, f_valid, q_full, q_empty, b_ready;
  logic signed [CW-1:0] f_nx, f_ny, q_nx, q_ny;

  tsp_front #(.FracBits(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_ready_o(f_ready),
    .x_i(cursor_x_i), .y_i(cursor_y_i), .w_i(width_q), .h_i(height_q),
    .out_valid_o(f_valid), .out_ready_i(!q_full),
    .nx_o(f_nx), .ny_o(f_ny)
  );

  assign full = !f_ready;

  // Queue: lets the front keep advancing while the back is held by the sink, until it is full.
  tsp_fifo #(.W(2 * CW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(f_valid), .data_i({f_nx, f_ny}), .full_o(q_full),
    .pop_i(b_ready), .data_o({q_nx, q_ny}), .empty_o(q_empty)
  );

  // Back: height on the sphere, length, and the unit vector. Its last
  // stage is the output register; hold it until the word is popped.
  logic b_valid;

  tsp_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(!q_empty), .in_ready_o(b_ready),
    .nx_i(q_nx), .ny_i(q_ny),
    .out_valid_o(b_valid), .out_ready_i(pop),
    .dir_x_o, .dir_y_o, .dir_z_o
  );

  assign empty = !b_valid;

endmodule

FILE: rtl/core/tsp_checker.sv
// Port checker for the trackball sphere projection block, bound to the top level.
module tsp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push,
  input logic                             full,
  input logic                             empty,
  input logic                             pop,
  input logic signed [tsp_pkg::OutW-1:0]  dir_x_o,
  input logic signed [tsp_pkg::OutW-1:0]  dir_y_o,
  input logic [tsp_pkg::OutZW-1:0]        dir_z_o
);

  // once reset has been seen at an edge, no result word may be shown at the next
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  // a held word keeps its value until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(dir_x_o) && $stable(dir_y_o)
                          && $stable(dir_z_o)))
    else $error("result word changed while held");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (dir_x_o >= -16'sd16384 && dir_x_o <= 16'sd16384))
    else $error("dir_x out of unit range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (dir_y_o >= -16'sd16384 && dir_y_o <= 16'sd16384))
    else $error("dir_y out of unit range");

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (dir_z_o <= 15'd16384 && dir_z_o != 15'd0))
    else $error("dir_z out of range");

endmodule

bind trackball_sphere_projection tsp_checker u_tsp_checker (.*);
